// File: hw/rtl/msas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msas_pkg
// Shared types, constants and lookup tables for the mouse-to-stick aim shaper.
// ----------------------------------------------------------------------------
package msas_pkg;

   localparam int ACC_FRAC_BITS_DEF = 8;
   localparam int LOG_DEPTH         = 256;
   localparam int LOG_IDX_W         = $clog2(LOG_DEPTH);
   localparam int PROF_W            = 60;
   localparam int CSR_DATA_W        = 64;
   localparam int CSR_ADDR_W        = 5;

   localparam logic [1:0] REG_HIP    = 2'd0;
   localparam logic [1:0] REG_ADS    = 2'd1;
   localparam logic [1:0] REG_INVERT = 2'd2;

   localparam logic [7:0] STICK_CENTER = 8'd128;
   localparam logic [7:0] STICK_MIN    = 8'd0;
   localparam logic [7:0] STICK_MAX    = 8'd255;

   localparam logic [63:0] ONE30 = 64'h1 << 30;

   typedef struct packed {
      logic signed [11:0] delta_x;
      logic signed [11:0] delta_y;
      logic               aim_mode;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] stick_x;
      logic [7:0] stick_y;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [11:0] delta;
      logic               neg;
      logic [15:0]        sens;
      logic [11:0]        wgt;
      logic [7:0]         curve;
      logic [7:0]         boost;
   } lane_cmd_type;

   typedef struct packed {
      logic start;
      logic take;
   } lane_ctl_type;

   typedef struct packed {
      logic       idle;
      logic       done;
      logic [7:0] stick;
   } lane_stat_type;

   typedef logic [15:0] log_tab_type [LOG_DEPTH];
   typedef logic [16:0] exp_tab_type [LOG_DEPTH];

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] b;
      v   = v_in;
      res = '0;
      b   = 64'h1 << 62;
      while (b > v) b = b >> 2;
      while (b != 64'h0) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic log_tab_type build_log_tab();
      log_tab_type tab;
      logic [63:0] x;
      logic [15:0] r;
      for (int i = 0; i < LOG_DEPTH; i++) begin
         x = ONE30 + ((64'(i) << 30) / LOG_DEPTH);
         r = '0;
         for (int k = 1; k <= 16; k++) begin
            x = (x * x) >> 30;
            if (x >= 2 * ONE30) begin
               x = x >> 1;
               r[16-k] = 1'b1;
            end
         end
         tab[i] = r;
      end
      return tab;
   endfunction

   function automatic exp_tab_type build_exp_tab();
      exp_tab_type tab;
      logic [63:0] root [17];
      logic [63:0] y;
      logic [63:0] f;
      root[0] = 64'h1 << 31;
      for (int k = 1; k <= 16; k++) root[k] = isqrt64(root[k-1] << 30);
      for (int i = 0; i < LOG_DEPTH; i++) begin
         f = (64'(i) << 16) / LOG_DEPTH;
         y = ONE30;
         for (int k = 1; k <= 16; k++) begin
            if (f[16-k]) y = (y * root[k]) >> 30;
         end
         tab[i] = 17'(y >> 14);
      end
      return tab;
   endfunction

   localparam log_tab_type LOG_TAB = build_log_tab();
   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

// File: hw/rtl/msas_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msas_stream_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface msas_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/msas_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msas_lane
// One axis: scale, smoothing average, log/exp curve and stick mapping,
// stepped by a small sequencer.
// ----------------------------------------------------------------------------
module msas_lane #(
   parameter int ACC_FRAC_BITS = msas_pkg::ACC_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  msas_pkg::lane_cmd_type cmd,
   input  msas_pkg::lane_ctl_type ctl,
   output msas_pkg::lane_stat_type stat
);
   import msas_pkg::*;

   localparam int SHL = (ACC_FRAC_BITS >= 8) ? ACC_FRAC_BITS - 8 : 0;
   localparam int SHR = (ACC_FRAC_BITS >= 8) ? 0 : 8 - ACC_FRAC_BITS;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_TGT  = 4'd1;
   localparam logic [3:0] ST_WGT  = 4'd2;
   localparam logic [3:0] ST_SUM  = 4'd3;
   localparam logic [3:0] ST_NORM = 4'd4;
   localparam logic [3:0] ST_LOG  = 4'd5;
   localparam logic [3:0] ST_CURV = 4'd6;
   localparam logic [3:0] ST_EXP  = 4'd7;
   localparam logic [3:0] ST_FIN  = 4'd8;
   localparam logic [3:0] ST_DONE = 4'd9;

   logic [3:0]          state_ff, state_in;
   lane_cmd_type        cmd_ff, cmd_in;
   logic signed [31:0]  acc_ff, acc_in;
   logic signed [33:0]  t_ff, t_in;
   logic signed [45:0]  p1_ff, p1_in;
   logic signed [46:0]  p2_ff, p2_in;
   logic [31:0]         a_ff, a_in;
   logic [4:0]          pos_ff, pos_in;
   logic [2:0]          step_ff, step_in;
   logic                neg_ff, neg_in;
   logic                ctr_ff, ctr_in;
   logic signed [22:0]  lg_ff, lg_in;
   logic signed [25:0]  e_ff, e_in;
   logic [23:0]         mag_ff, mag_in;
   logic [7:0]          stick_ff, stick_in;

   logic signed [12:0]  d13;
   logic signed [29:0]  prod;
   logic signed [47:0]  sum;
   logic signed [47:0]  snew;
   logic signed [31:0]  ssat;
   logic [4:0]          sh;
   logic signed [6:0]   pexp;
   logic signed [31:0]  ecalc;
   logic [9:0]          ei;
   logic [36:0]         q;
   logic [24:0]         total;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      acc_in   = acc_ff;
      t_in     = t_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      a_in     = a_ff;
      pos_in   = pos_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      ctr_in   = ctr_ff;
      lg_in    = lg_ff;
      e_in     = e_ff;
      mag_in   = mag_ff;
      stick_in = stick_ff;

      d13   = cmd_ff.neg ? -13'(cmd_ff.delta) : 13'(cmd_ff.delta);
      prod  = d13 * signed'({1'b0, cmd_ff.sens});
      sum   = 48'(p1_ff) + 48'(p2_ff) + 48'sd2048;
      snew  = sum >>> 12;
      if (snew > 48'sh7FFF_FFFF) begin
         ssat = 32'sh7FFF_FFFF;
      end else if (snew < -48'sh8000_0000) begin
         ssat = -32'sh8000_0000;
      end else begin
         ssat = snew[31:0];
      end
      sh    = 5'd16 >> step_ff;
      pexp  = 7'(pos_ff) - 7'(ACC_FRAC_BITS);
      ecalc = lg_ff * signed'({1'b0, cmd_ff.curve});
      ei    = e_ff[25:16];
      q     = 37'(EXP_TAB[e_ff[15 -: LOG_IDX_W]]) << ei[4:0];
      total = 25'(cmd_ff.boost) + 25'(mag_ff);

      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               cmd_in   = cmd;
               state_in = ST_TGT;
            end
         end
         ST_TGT: begin
            t_in     = (34'(prod) <<< SHL) >>> SHR;
            p1_in    = acc_ff * signed'({1'b0, 13'(13'd4096 - {1'b0, cmd_ff.wgt})});
            state_in = ST_WGT;
         end
         ST_WGT: begin
            p2_in    = t_ff * signed'({1'b0, cmd_ff.wgt});
            state_in = ST_SUM;
         end
         ST_SUM: begin
            acc_in  = ssat;
            neg_in  = ssat[31];
            ctr_in  = (ssat == 32'sd0);
            a_in    = ssat[31] ? 32'(-ssat) : 32'(ssat);
            pos_in  = 5'd31;
            step_in = '0;
            state_in = (ssat == 32'sd0) ? ST_FIN : ST_NORM;
         end
         ST_NORM: begin
            if ((a_ff >> (6'd32 - 6'(sh))) == 32'd0) begin
               a_in   = a_ff << sh;
               pos_in = pos_ff - sh;
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd4) state_in = ST_LOG;
         end
         ST_LOG: begin
            lg_in    = signed'({pexp, 16'h0}) + signed'({7'd0, LOG_TAB[a_ff[30 -: LOG_IDX_W]]});
            state_in = ST_CURV;
         end
         ST_CURV: begin
            e_in     = 26'(ecalc >>> 6);
            state_in = ST_EXP;
         end
         ST_EXP: begin
            if (e_ff <= 26'sd0) begin
               ctr_in = 1'b1;
            end else if (ei > 10'd20) begin
               mag_in = 24'hFF_FFFF;
            end else begin
               ctr_in = (q <= 37'd65536);
               mag_in = 24'(q >> 16);
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (ctr_ff) begin
               stick_in = STICK_CENTER;
            end else if (!neg_ff) begin
               stick_in = (total > 25'd127) ? STICK_MAX : STICK_CENTER + total[7:0];
            end else begin
               stick_in = (total > 25'd128) ? STICK_MIN : STICK_CENTER - total[7:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ctl.take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         acc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
      end
      cmd_ff   <= cmd_in;
      t_ff     <= t_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      a_ff     <= a_in;
      pos_ff   <= pos_in;
      step_ff  <= step_in;
      neg_ff   <= neg_in;
      ctr_ff   <= ctr_in;
      lg_ff    <= lg_in;
      e_ff     <= e_in;
      mag_ff   <= mag_in;
      stick_ff <= stick_in;
   end

   assign stat.idle  = (state_ff == ST_IDLE);
   assign stat.done  = (state_ff == ST_DONE);
   assign stat.stick = stick_ff;

endmodule

// File: hw/rtl/msas_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msas_merge
// Joins both lane results into one output item held in an output register.
// ----------------------------------------------------------------------------
module msas_merge (
   input  logic                     clock,
   input  logic                     reset,
   input  msas_pkg::lane_stat_type  stat_x,
   input  msas_pkg::lane_stat_type  stat_y,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output msas_pkg::rsp_payload_type rsp_payload,
   output logic                     take
);
   import msas_pkg::*;

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff, data_in;

   assign take = stat_x.done && stat_y.done && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (rsp_ready) valid_in = 1'b0;
      if (take) begin
         valid_in        = 1'b1;
         data_in.stick_x = stat_x.stick;
         data_in.stick_y = stat_y.stick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

// File: hw/rtl/mouse_to_stick_aim_shaper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_to_stick_aim_shaper_top
// Turns mouse deltas into right-stick positions through a per-profile
// sensitivity, smoothing average and response curve.
// ----------------------------------------------------------------------------
// Two lanes, one per axis, run side by side on each item. Each lane steps
// through target scaling, smoothing, a five-step normalize, log lookup,
// curve multiply, exp lookup and stick mapping; a lane whose smoothed
// average comes out zero goes straight from smoothing to stick mapping.
// The lanes take the next item in the cycle after their results move
// into the output register, so one item is in flight at a time; the
// lane sequencer sets the pace. A stalled output adds its stall cycles
// once a second result is ready. The output register lets a new item
// enter while a result waits.
// Profiles sit at byte addresses 0 and 8, the axis invert bits at 16.
module mouse_to_stick_aim_shaper_top #(
   parameter int ACC_FRAC_BITS = msas_pkg::ACC_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   msas_stream_if.sink                         req_chan,
   msas_stream_if.source                       rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [msas_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [msas_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [msas_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import msas_pkg::*;

   logic [PROF_W-1:0] hip_ff, hip_in;
   logic [PROF_W-1:0] ads_ff, ads_in;
   logic [1:0]        inv_ff, inv_in;

   logic              csr_wr;
   logic [1:0]        csr_idx;
   logic [PROF_W-1:0] prof;
   req_payload_type   req_item;
   lane_cmd_type      cmd_x, cmd_y;
   lane_ctl_type      ctl;
   lane_stat_type     stat_x, stat_y;
   logic              take;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[4:3];

   always_comb begin
      hip_in = hip_ff;
      ads_in = ads_ff;
      inv_in = inv_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_HIP:    hip_in = pwdata[PROF_W-1:0];
            REG_ADS:    ads_in = pwdata[PROF_W-1:0];
            REG_INVERT: inv_in = pwdata[1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_HIP:    prdata = CSR_DATA_W'(hip_ff);
         REG_ADS:    prdata = CSR_DATA_W'(ads_ff);
         REG_INVERT: prdata = CSR_DATA_W'(inv_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hip_ff <= '0;
         ads_ff <= '0;
         inv_ff <= '0;
      end else begin
         hip_ff <= hip_in;
         ads_ff <= ads_in;
         inv_ff <= inv_in;
      end
   end

   assign req_item       = req_chan.payload;
   assign prof           = req_item.aim_mode ? ads_ff : hip_ff;
   assign req_chan.ready = stat_x.idle && stat_y.idle;

   assign cmd_x.delta = req_item.delta_x;
   assign cmd_x.neg   = inv_ff[0];
   assign cmd_x.sens  = prof[15:0];
   assign cmd_x.wgt   = prof[43:32];
   assign cmd_x.curve = prof[51:44];
   assign cmd_x.boost = prof[59:52];

   assign cmd_y.delta = req_item.delta_y;
   assign cmd_y.neg   = inv_ff[1];
   assign cmd_y.sens  = prof[31:16];
   assign cmd_y.wgt   = prof[43:32];
   assign cmd_y.curve = prof[51:44];
   assign cmd_y.boost = prof[59:52];

   assign ctl.start = req_chan.valid && req_chan.ready;
   assign ctl.take  = take;

   msas_lane #(.ACC_FRAC_BITS(ACC_FRAC_BITS)) u_lane_x (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_x),
      .ctl   (ctl),
      .stat  (stat_x)
   );

   msas_lane #(.ACC_FRAC_BITS(ACC_FRAC_BITS)) u_lane_y (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_y),
      .ctl   (ctl),
      .stat  (stat_y)
   );

   msas_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .stat_x      (stat_x),
      .stat_y      (stat_y),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_payload (rsp_chan.payload),
      .take        (take)
   );

endmodule

// File: hw/rtl/msas_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msas_checker
// Port-level checks on the aim shaper channels, bound to the top level.
// ----------------------------------------------------------------------------
module msas_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_bits
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_bits))
      else $error("result item changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while an item is in work");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result appeared one cycle after acceptance");

endmodule

bind mouse_to_stick_aim_shaper_top msas_checker u_msas_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_bits  (rsp_chan.payload)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mouse-to-stick aim shaper: programs profiles and
// invert bits over APB, streams mouse deltas with bursty input and a stalling
// output, and checks every stick position against an in-bench shaping model.
// ----------------------------------------------------------------------------
module tb;
   import msas_pkg::*;

   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   msas_stream_if #(.payload_type(req_payload_type)) req_if ();
   msas_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   mouse_to_stick_aim_shaper_top dut (
      .clock(clock), .reset(reset), .req_chan(req_if.sink), .rsp_chan(rsp_if.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shaping model state
   longint unsigned log2_lut [256];
   longint unsigned exp2_lut [256];
   logic [59:0] hip_prof, ads_prof;
   logic [1:0]  invert_bits;
   longint      avg_x, avg_y;

   req_payload_type pending_q [$];
   rsp_payload_type stick_q [$];
   int  n_sent, n_checked, n_errors, idle_cycles;
   bit  req_took;
   int  burst_left, gap_left, stall_pct, hold_left;
   bit  hold_req;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   function automatic void build_luts();
      longint unsigned root [17];
      longint unsigned x, y, f;
      logic [15:0] r;
      root[0] = 64'd1 << 31;
      for (int k = 1; k <= 16; k++) root[k] = int_sqrt(root[k-1] << 30);
      for (int i = 0; i < 256; i++) begin
         x = (64'd1 << 30) + ((64'(i) << 30) / 256);
         r = '0;
         for (int k = 1; k <= 16; k++) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
               x = x >> 1;
               r[16-k] = 1'b1;
            end
         end
         log2_lut[i] = 64'(r);
         f = (64'(i) << 16) / 256;
         y = 64'd1 << 30;
         for (int k = 1; k <= 16; k++)
            if (f[16-k]) y = (y * root[k]) >> 30;
         exp2_lut[i] = y >> 14;
      end
   endfunction

   function automatic logic [7:0] shape_axis(inout longint acc, input longint d,
                                             input bit neg, input longint sens,
                                             input longint w, input longint curve,
                                             input longint boost);
      longint t, s, lg, e, o;
      longint unsigned a, m30, q, mag;
      logic [7:0] li, xi;
      int p;
      if (neg) d = -d;
      t = (d * sens) <<< (ACC_FRAC_BITS_DEF - 8);
      s = (acc * (4096 - w) + t * w + 2048) >>> 12;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      acc = s;
      if (s == 0) return STICK_CENTER;
      a = (s < 0) ? -s : s;
      p = 63;
      while (a[p] == 1'b0) p--;
      m30 = (p <= 30) ? (a << (30 - p)) : (a >> (p - 30));
      li = 8'((((m30 - (64'd1 << 30)) * 256) >> 30));
      lg = longint'(p - ACC_FRAC_BITS_DEF) * 65536 + longint'(log2_lut[li]);
      e = (lg * curve) >>> 6;
      if (e <= 0) return STICK_CENTER;
      if ((e >>> 16) > 20) begin
         mag = 64'hFFFFFF;
      end else begin
         xi = 8'((((e & 64'hFFFF) * 256) >> 16));
         q = exp2_lut[xi] << (e >>> 16);
         if (q <= 65536) return STICK_CENTER;
         mag = q >> 16;
      end
      o = boost + longint'(mag);
      o = (s > 0) ? 128 + o : 128 - o;
      if (o < 0) o = 0;
      if (o > 255) o = 255;
      return o[7:0];
   endfunction

   function automatic rsp_payload_type predict_stick(req_payload_type it);
      rsp_payload_type r;
      logic [59:0] pf;
      pf = it.aim_mode ? ads_prof : hip_prof;
      r.stick_x = shape_axis(avg_x, longint'(it.delta_x), invert_bits[0], 64'(pf[15:0]),
                             64'(pf[43:32]), 64'(pf[51:44]), 64'(pf[59:52]));
      r.stick_y = shape_axis(avg_y, longint'(it.delta_y), invert_bits[1], 64'(pf[31:16]),
                             64'(pf[43:32]), 64'(pf[51:44]), 64'(pf[59:52]));
      return r;
   endfunction

   task automatic csr_write(logic [1:0] idx, logic [63:0] val);
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
      paddr = CSR_ADDR_W'(idx) << 3; pwdata = val;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
      case (idx)
         REG_HIP:    hip_prof = val[59:0];
         REG_ADS:    ads_prof = val[59:0];
         REG_INVERT: invert_bits = val[1:0];
         default: ;
      endcase
   endtask

   function automatic logic [63:0] rand_profile();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: v[15:0] = 16'($urandom_range(0, 1023));
         1: v[15:0] = 16'hFFFF;
         default: ;
      endcase
      case ($urandom_range(0, 3))
         0: v[31:16] = 16'($urandom_range(0, 1023));
         1: v[31:16] = 16'h0000;
         default: ;
      endcase
      case ($urandom_range(0, 4))
         0: v[43:32] = 12'd0;
         1: v[43:32] = 12'hFFF;
         default: ;
      endcase
      case ($urandom_range(0, 4))
         0: v[51:44] = 8'd0;
         1: v[51:44] = 8'd64;
         2: v[51:44] = 8'($urandom_range(1, 40));
         default: ;
      endcase
      if ($urandom_range(0, 1)) v[59:52] = 8'($urandom_range(0, 20));
      return v;
   endfunction

   function automatic req_payload_type rand_item();
      req_payload_type it;
      it.aim_mode = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 2) == 0) begin
         it.delta_x = 12'($urandom);
         it.delta_y = 12'($urandom);
      end else begin
         it.delta_x = 12'($signed($urandom_range(0, 80)) - 40);
         it.delta_y = 12'($signed($urandom_range(0, 80)) - 40);
      end
      return it;
   endfunction

   function automatic void push_item(int dx, int dy, bit am);
      req_payload_type it;
      it.delta_x = 12'(dx);
      it.delta_y = 12'(dy);
      it.aim_mode = am;
      pending_q.push_back(it);
   endfunction

   task automatic drain();
      wait (pending_q.size() == 0 && stick_q.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   // sender: bursts and gaps, hold the item until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid = 1'b0;
         req_if.payload = '0;
      end else if (!req_if.valid || req_took) begin
         req_took = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid = 1'b0;
         end else if (pending_q.size() > 0) begin
            req_if.valid = 1'b1;
            req_if.payload = pending_q[0];
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end
         end else begin
            req_if.valid = 1'b0;
         end
      end
   end

   // receiver: random stall pattern plus an occasional long hold
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = 150;
      end
      if (reset) begin
         rsp_if.ready = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready = 1'b0;
      end else begin
         rsp_if.ready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (req_if.valid && req_if.ready) begin
            stick_q.push_back(predict_stick(req_if.payload));
            void'(pending_q.pop_front());
            req_took = 1'b1;
            n_sent++;
            idle_cycles = 0;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            idle_cycles = 0;
            if (stick_q.size() == 0) begin
               $display("%0t: unexpected item x=%0d y=%0d", $time,
                        rsp_if.payload.stick_x, rsp_if.payload.stick_y);
               n_errors++;
            end else begin
               if (rsp_if.payload.stick_x !== stick_q[0].stick_x) begin
                  $display("%0t: stick_x expected %0d actual %0d", $time,
                           stick_q[0].stick_x, rsp_if.payload.stick_x);
                  n_errors++;
               end
               if (rsp_if.payload.stick_y !== stick_q[0].stick_y) begin
                  $display("%0t: stick_y expected %0d actual %0d", $time,
                           stick_q[0].stick_y, rsp_if.payload.stick_y);
                  n_errors++;
               end
               void'(stick_q.pop_front());
               n_checked++;
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no progress", $time);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      build_luts();
      hip_prof = '0; ads_prof = '0; invert_bits = '0;
      avg_x = 0; avg_y = 0;
      req_if.valid = 1'b0; req_if.payload = '0; rsp_if.ready = 1'b0;
      stall_pct = 0; hold_left = 0; hold_req = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset profiles: everything centers
      push_item(2047, -2048, 0);
      push_item(-2048, 2047, 1);
      drain();

      // unit sensitivity, fast average, linear curve
      csr_write(REG_HIP, {4'hF, 8'd0, 8'd64, 12'hFFF, 16'h0100, 16'h0100});
      csr_write(REG_ADS, {4'h0, 8'd255, 8'd255, 12'd0, 16'hFFFF, 16'hFFFF});
      csr_write(REG_INVERT, 64'd0);
      csr_write(REG_SPARE, 64'd3);
      push_item(0, 0, 0);
      push_item(1, -1, 0);
      push_item(2047, -2048, 0);
      push_item(-2048, 2047, 0);
      push_item(100, -100, 1);
      push_item(5, 5, 0);
      push_item(0, 0, 0);
      push_item(-3, 300, 0);
      drain();

      // steep curve with boost, zero curve, inverted axes
      csr_write(REG_HIP, {4'h0, 8'd200, 8'd255, 12'd2048, 16'h0200, 16'h0080});
      csr_write(REG_ADS, {4'h0, 8'd10, 8'd0, 12'hFFF, 16'h0100, 16'h0100});
      csr_write(REG_INVERT, 64'd3);
      push_item(2047, 2047, 0);
      push_item(-2048, -2048, 0);
      push_item(1, 1, 0);
      push_item(700, -700, 1);
      push_item(0, 0, 0);
      push_item(-1, 1, 1);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         csr_write(REG_HIP, rand_profile());
         csr_write(REG_ADS, rand_profile());
         csr_write(REG_INVERT, 64'($urandom_range(0, 3)));
         stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 80);
         for (int i = 0; i < 50; i++) pending_q.push_back(rand_item());
         if (ph == 2 || ph == 6) hold_req = 1'b1;
         drain();
      end

      repeat (30) @(posedge clock);
      $display("Sent %0d items over 11 register settings, checked %0d stick results",
               n_sent, n_checked);
      if (n_errors == 0 && stick_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/msas_pkg.sv
hw/rtl/msas_stream_if.sv
hw/rtl/msas_lane.sv
hw/rtl/msas_merge.sv
hw/rtl/mouse_to_stick_aim_shaper_top.sv
hw/rtl/msas_checker.sv
verif/tb.sv
